>>> rtl/core/rmsm_pkg.sv
// Shared types, constants and widths of the RMS current, power and energy meter.
package rmsm_pkg;

    localparam int WINDOW_SAMPLES_DEF = 100;
    localparam int SAMPLE_BITS_DEF    = 12;

    localparam int ADC_W      = 12;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int CUR_W      = 17;
    localparam int VOLT_W     = 13;
    localparam int PWR_W      = 26;
    localparam int EGY_W      = 48;
    localparam int EL_W       = 32;
    localparam int ACC_W      = 64;
    localparam int PPR_W      = CUR_W + VOLT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    localparam int DIV_W     = 64;
    localparam int DVSR_W    = 22;
    localparam int DIV_CNT_W = 6;
    localparam int PWR_STEPS = PPR_W / 2;
    localparam int EGY_STEPS = DIV_W / 2;

    localparam logic [CUR_W-1:0]  CURRENT_MAX = 17'd131071;
    localparam logic [PWR_W-1:0]  POWER_MAX   = 26'd67108863;
    localparam logic [EL_W-1:0]   ELAPSED_MAX = 32'hFFFF_FFFF;
    localparam logic [DVSR_W-1:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [DVSR_W-1:0] DV_PER_V    = 22'd10;

    localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd3200000;
    localparam logic [CUR_W-1:0]  FLOOR_RST = 17'd50;
    localparam logic [VOLT_W-1:0] MAINS_RST = 13'd2300;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINS = 2'd2;

    typedef struct packed {
        logic             op;
        logic [ADC_W-1:0] adc_sample;
    } t_in;

    typedef struct packed {
        logic [CUR_W-1:0] current_ma;
        logic [PWR_W-1:0] power_mw;
        logic [EGY_W-1:0] energy_mwh;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] current_gain_q16;
        logic [CUR_W-1:0]  noise_floor_ma;
        logic [VOLT_W-1:0] mains_voltage_dv;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic almost_full;
        logic full;
    } t_q_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MEAN,
        BK_ROOT,
        BK_CMUL,
        BK_CSAT,
        BK_PMUL,
        BK_PDIV,
        BK_EMUL,
        BK_EACC,
        BK_EDIV,
        BK_OUT
    } t_bk_state;

endpackage

>>> rtl/core/rmsm_fifo.sv
// Short job queue between the sample front end and the window back end.
module rmsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output rmsm_pkg::t_q_status   o_stat
);
    import rmsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data             = r_mem[r_rptr];
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.almost_full = (r_count >= CNT_W'(DEPTH - 1));
    assign o_stat.full        = (r_count == CNT_W'(DEPTH));

endmodule

>>> rtl/core/rmsm_front.sv
// Front end: accepts samples and ticks, accumulates squares and closes windows.
module rmsm_front #(
    parameter int WINDOW_SAMPLES = 100,
    parameter int SAMPLE_BITS    = 12,
    localparam int SUM_W = 2 * SAMPLE_BITS - 2 + $clog2(WINDOW_SAMPLES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  rmsm_pkg::t_in               i_in,
    output logic                        o_in_stall,
    input  rmsm_pkg::t_q_status         i_q_stat,
    output logic                        o_push,
    output logic [SUM_W-1:0]            o_push_sum,
    output logic [rmsm_pkg::EL_W-1:0]   o_push_el
);
    import rmsm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SB - 1;
    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [EL_W-1:0]   r_el;
    logic [SUM_W-1:0]  r_sum;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic [SQ_W-1:0]   r_s1_sq;
    logic [EL_W-1:0]   r_s1_el;

    logic              w_accept;
    logic              w_last;
    logic [SB-1:0]     w_smp;
    logic [SB-1:0]     w_mid;
    logic [SB-1:0]     w_dev;
    logic [2*SB-1:0]   w_sq;
    logic [SUM_W-1:0]  w_sum_next;

    assign o_in_stall = i_q_stat.full || (i_q_stat.almost_full && r_s1_valid && r_s1_last);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_smp = SB'(i_in.adc_sample);
    assign w_mid = SB'(1) << (SB - 1);
    assign w_dev = (w_smp >= w_mid) ? (w_smp - w_mid) : (w_mid - w_smp);
    assign w_sq  = (2 * SB)'(w_dev) * (2 * SB)'(w_dev);
    assign w_last = (r_cnt == CNT_W'(WINDOW_SAMPLES - 1));

    assign w_sum_next = r_sum + SUM_W'(r_s1_sq);
    assign o_push     = r_s1_valid && r_s1_last;
    assign o_push_sum = w_sum_next;
    assign o_push_el  = r_s1_el;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_el       <= '0;
            r_sum      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && (i_in.op == OP_SAMPLE);
            r_s1_last  <= w_accept && (i_in.op == OP_SAMPLE) && w_last;
            if (w_accept) begin
                if (i_in.op == OP_TICK) begin
                    if (r_el != ELAPSED_MAX) begin
                        r_el <= r_el + 1'b1;
                    end
                end else if (w_last) begin
                    r_cnt <= '0;
                    r_el  <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_s1_valid) begin
                r_sum <= r_s1_last ? '0 : w_sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sq <= w_sq[SQ_W-1:0];
            r_s1_el <= r_el;
        end
    end

endmodule

>>> rtl/core/rmsm_div.sv
// Shared iterative divider that retires two quotient bits per cycle.
module rmsm_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rmsm_pkg::DIV_CNT_W-1:0]     i_steps,
    input  logic [rmsm_pkg::DIV_W-1:0]         i_dividend,
    input  logic [rmsm_pkg::DVSR_W-1:0]        i_divisor,
    output logic                               o_done,
    output logic [rmsm_pkg::DIV_W-1:0]         o_quot
);
    import rmsm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]      r_q;
    logic [DVSR_W-1:0]     r_rem;
    logic [DVSR_W-1:0]     r_dvsr;

    logic [DVSR_W:0]       w_t1;
    logic [DVSR_W:0]       w_t2;
    logic                  w_ge1;
    logic                  w_ge2;
    logic [DVSR_W-1:0]     w_m1;
    logic [DVSR_W-1:0]     w_m2;

    always_comb begin
        w_t1  = {r_rem, r_q[DIV_W-1]};
        w_ge1 = (w_t1 >= {1'b0, r_dvsr});
        w_m1  = w_ge1 ? DVSR_W'(w_t1 - {1'b0, r_dvsr}) : DVSR_W'(w_t1);
        w_t2  = {w_m1, r_q[DIV_W-2]};
        w_ge2 = (w_t2 >= {1'b0, r_dvsr});
        w_m2  = w_ge2 ? DVSR_W'(w_t2 - {1'b0, r_dvsr}) : DVSR_W'(w_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps - 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-3:0], w_ge1, w_ge2};
            r_rem <= w_m2;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/core/rmsm_back.sv
// Back end: mean, square root, scaling, power and energy for each closed window.
module rmsm_back #(
    parameter int WINDOW_SAMPLES = 100,
    parameter int SAMPLE_BITS    = 12,
    localparam int SUM_W = 2 * SAMPLE_BITS - 2 + $clog2(WINDOW_SAMPLES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  logic [SUM_W-1:0]            i_job_sum,
    input  logic [rmsm_pkg::EL_W-1:0]   i_job_el,
    output logic                        o_job_pop,
    input  rmsm_pkg::t_cfg              i_cfg,
    output logic                        o_out_valid,
    output rmsm_pkg::t_out              o_out,
    input  logic                        i_out_stall
);
    import rmsm_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int SUM_PAD   = 2 * ((SUM_W + 1) / 2);
    localparam int SUM_STEPS = SUM_PAD / 2;
    localparam int MEAN_W    = 2 * SB - 1;
    localparam int RT_W      = SB;
    localparam int SQV_W     = 2 * SB;
    localparam int RT_CNT_W  = $clog2(SB);
    localparam int CPROD_W   = RT_W + GAIN_W;
    localparam int INC_W     = PWR_W + EL_W;

    t_bk_state             r_state;
    t_bk_state             n_state;

    logic [EL_W-1:0]       r_el;
    logic [SQV_W-1:0]      r_sqv;
    logic [RT_W+1:0]       r_rem;
    logic [RT_W-1:0]       r_root;
    logic [RT_CNT_W-1:0]   r_rcnt;
    logic [CPROD_W-1:0]    r_cprod;
    logic [CUR_W-1:0]      r_cur;
    logic [PWR_W-1:0]      r_pwr;
    logic [INC_W-1:0]      r_inc;
    logic [ACC_W-1:0]      r_energy;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  w_div_start;
    logic [DIV_CNT_W-1:0]  w_div_steps;
    logic [DIV_W-1:0]      w_div_dividend;
    logic [DVSR_W-1:0]     w_div_divisor;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_div_quot;
    logic                  w_out_load;

    logic [RT_W+3:0]       w_trem;
    logic [RT_W+3:0]       w_trial;
    logic                  w_rge;
    logic [CPROD_W-1:0]    w_cur_ext;
    logic [CUR_W-1:0]      w_cur_sat;
    logic [PPR_W-1:0]      w_pprod;
    logic [PPR_W-1:0]      w_pq;
    logic [ACC_W:0]        w_esum;
    logic [ACC_W-1:0]      w_esat;

    rmsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_steps    (w_div_steps),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_comb begin
        w_trem    = {r_rem, r_sqv[SQV_W-1 -: 2]};
        w_trial   = (RT_W + 4)'({r_root, 2'b01});
        w_rge     = (w_trem >= w_trial);
        w_cur_ext = r_cprod >> GAIN_FRAC;
        w_cur_sat = (w_cur_ext > CPROD_W'(CURRENT_MAX)) ? CURRENT_MAX : w_cur_ext[CUR_W-1:0];
        w_pprod   = PPR_W'(r_cur) * PPR_W'(i_cfg.mains_voltage_dv);
        w_pq      = w_div_quot[PPR_W-1:0];
        w_esum    = {1'b0, r_energy} + (ACC_W + 1)'(r_inc);
        w_esat    = w_esum[ACC_W] ? '1 : w_esum[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_job_pop      = 1'b0;
        w_div_start    = 1'b0;
        w_div_steps    = '0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        w_out_load     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop      = 1'b1;
                    w_div_start    = 1'b1;
                    w_div_steps    = DIV_CNT_W'(SUM_STEPS);
                    w_div_dividend = DIV_W'(i_job_sum) << (DIV_W - SUM_PAD);
                    w_div_divisor  = DVSR_W'(WINDOW_SAMPLES);
                    n_state        = BK_MEAN;
                end
            end
            BK_MEAN: begin
                if (w_div_done) begin
                    n_state = BK_ROOT;
                end
            end
            BK_ROOT: begin
                if (r_rcnt == RT_CNT_W'(RT_W - 1)) begin
                    n_state = BK_CMUL;
                end
            end
            BK_CMUL: n_state = BK_CSAT;
            BK_CSAT: n_state = BK_PMUL;
            BK_PMUL: begin
                w_div_start    = 1'b1;
                w_div_steps    = DIV_CNT_W'(PWR_STEPS);
                w_div_dividend = DIV_W'(w_pprod) << (DIV_W - PPR_W);
                w_div_divisor  = DV_PER_V;
                n_state        = BK_PDIV;
            end
            BK_PDIV: begin
                if (w_div_done) begin
                    n_state = BK_EMUL;
                end
            end
            BK_EMUL: n_state = BK_EACC;
            BK_EACC: begin
                w_div_start    = 1'b1;
                w_div_steps    = DIV_CNT_W'(EGY_STEPS);
                w_div_dividend = w_esat;
                w_div_divisor  = MS_PER_HOUR;
                n_state        = BK_EDIV;
            end
            BK_EDIV: begin
                if (w_div_done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end
            if (r_state == BK_EACC) begin
                r_energy <= w_esat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_el <= i_job_el;
        end
        if (r_state == BK_MEAN && w_div_done) begin
            r_sqv  <= {1'b0, w_div_quot[MEAN_W-1:0]};
            r_rem  <= '0;
            r_root <= '0;
            r_rcnt <= '0;
        end
        if (r_state == BK_ROOT) begin
            r_sqv  <= r_sqv << 2;
            r_rem  <= w_rge ? (RT_W + 2)'(w_trem - w_trial) : (RT_W + 2)'(w_trem);
            r_root <= {r_root[RT_W-2:0], w_rge};
            r_rcnt <= r_rcnt + 1'b1;
        end
        if (r_state == BK_CMUL) begin
            r_cprod <= CPROD_W'(r_root) * CPROD_W'(i_cfg.current_gain_q16);
        end
        if (r_state == BK_CSAT) begin
            r_cur <= (w_cur_sat < i_cfg.noise_floor_ma) ? '0 : w_cur_sat;
        end
        if (r_state == BK_PDIV && w_div_done) begin
            r_pwr <= (w_pq > PPR_W'(POWER_MAX)) ? POWER_MAX : w_pq[PWR_W-1:0];
        end
        if (r_state == BK_EMUL) begin
            r_inc <= INC_W'(r_pwr) * INC_W'(r_el);
        end
        if (w_out_load) begin
            r_out.current_ma <= r_cur;
            r_out.power_mw   <= r_pwr;
            r_out.energy_mwh <= w_div_quot[EGY_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/rms_current_power_energy_meter_core.sv
// Top level of the RMS current, power and energy meter with its configuration registers.
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   t_in  (op, adc_sample)
// out      output     o_out_valid / i_out_stall t_out (current_ma, power_mw, energy_mwh)
// cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// The front end takes one transaction per cycle while not stalled. The delay from the
// sample that closes a window to its result is set by the shared two-bit-per-cycle
// divider, used three times per window, and the one-bit square root. A two-entry queue
// holds closed windows; input stalls when it is full, or holds one as another closes.
// Reset is synchronous and active low and clears all accumulators; there is no clear pass.
module rms_current_power_energy_meter_core #(
    parameter int WINDOW_SAMPLES = rmsm_pkg::WINDOW_SAMPLES_DEF,
    parameter int SAMPLE_BITS    = rmsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  rmsm_pkg::t_in                       i_in,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output rmsm_pkg::t_out                      o_out,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [rmsm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rmsm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rmsm_pkg::*;

    localparam int SUM_W = 2 * SAMPLE_BITS - 2 + $clog2(WINDOW_SAMPLES + 1);
    localparam int JOB_W = EL_W + SUM_W;

    t_cfg              r_cfg;
    t_q_status         w_q_stat;
    logic              w_push;
    logic              w_pop;
    logic [SUM_W-1:0]  w_push_sum;
    logic [EL_W-1:0]   w_push_el;
    logic [JOB_W-1:0]  w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_gain_q16 <= GAIN_RST;
            r_cfg.noise_floor_ma   <= FLOOR_RST;
            r_cfg.mains_voltage_dv <= MAINS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:  r_cfg.current_gain_q16 <= i_cfg_wdata[GAIN_W-1:0];
                CFG_FLOOR: r_cfg.noise_floor_ma   <= i_cfg_wdata[CUR_W-1:0];
                CFG_MAINS: r_cfg.mains_voltage_dv <= i_cfg_wdata[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    rmsm_front #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_push_sum (w_push_sum),
        .o_push_el  (w_push_el)
    );

    rmsm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_el, w_push_sum}),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    rmsm_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_stat.empty),
        .i_job_sum   (w_q_data[SUM_W-1:0]),
        .i_job_el    (w_q_data[JOB_W-1:SUM_W]),
        .o_job_pop   (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("Window queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("Window queue read while empty.");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> o_in_stall)
        else $error("Input not stalled with the window queue full.");

endmodule
